@@ rtl/srx_pkg.sv @@
// ----------------------------------------------------------------------------
// srx_pkg
// Shared types and constants for the systematic resampling index engine.
// ----------------------------------------------------------------------------
package srx_pkg;

  localparam int WEIGHT_W  = 16;
  localparam int SLOT_W    = 10;
  localparam int SRC_W     = 10;
  localparam int CFG_W     = 11;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 16;
  localparam int M_TUSER_W = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MULT,
    ST_CMP,
    ST_OUT
  } srx_state_t;

  typedef struct packed {
    logic load_en;
    logic query_start;
    logic rd_en;
    logic mul_en;
    logic cmp_en;
    logic out_load;
  } srx_cmd_t;

  typedef struct packed {
    logic set_complete;
    logic search_done;
    logic out_full;
  } srx_status_t;

endpackage

@@ rtl/srx_ctrl.sv @@
// ----------------------------------------------------------------------------
// srx_ctrl
// Sequencer: takes items, steps the binary search, hands results out.
// ----------------------------------------------------------------------------
module srx_ctrl
  import srx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_op,
  output logic        in_ready,
  input  srx_status_t status,
  output srx_cmd_t    cmd
);

  srx_state_t state;
  srx_state_t state_next;
  logic       accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && in_op == OP_QUERY) begin
          // no complete set: answer straight away
          state_next = status.set_complete ? ST_READ : ST_OUT;
        end
      end
      ST_READ: begin
        state_next = status.search_done ? ST_OUT : ST_MULT;
      end
      ST_MULT: state_next = ST_CMP;
      ST_CMP:  state_next = ST_READ;
      ST_OUT: begin
        if (!status.out_full) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready        = 1'b1;
        cmd.load_en     = accept && in_op == OP_LOAD;
        cmd.query_start = accept && in_op == OP_QUERY;
      end
      ST_READ: cmd.rd_en    = !status.search_done;
      ST_MULT: cmd.mul_en   = 1'b1;
      ST_CMP:  cmd.cmp_en   = 1'b1;
      ST_OUT:  cmd.out_load = !status.out_full;
      default: cmd          = '0;
    endcase
  end

endmodule

@@ rtl/srx_dp.sv @@
// ----------------------------------------------------------------------------
// srx_dp
// Datapath: cumulative weight store, running total, search bounds,
// threshold and product registers, result register.
// ----------------------------------------------------------------------------
module srx_dp
  import srx_pkg::*;
#(
  parameter int MAX_PARTICLES = 1024,
  parameter int WEIGHT_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [WEIGHT_W-1:0]  weight,
  input  logic [SLOT_W-1:0]    slot,
  input  srx_cmd_t             cmd,
  output srx_status_t          status,
  input  logic                 out_take,
  output logic                 out_valid,
  output logic [SRC_W-1:0]     out_source,
  output logic                 out_mean,
  output logic                 out_not_ready
);

  localparam int IDX_W   = $clog2(MAX_PARTICLES);
  localparam int LP_W    = $clog2(MAX_PARTICLES + 1);
  localparam int SUM_W   = WEIGHT_BITS + IDX_W;
  localparam int THR_W   = SUM_W + SLOT_W;
  localparam int PROD_W  = SUM_W + LP_W;
  localparam int CMP_W   = (THR_W > PROD_W) ? THR_W : PROD_W;
  localparam int CW      = (CFG_W > LP_W) ? CFG_W : LP_W;
  localparam int WB_IN   = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;

  logic [SUM_W-1:0] store [MAX_PARTICLES];

  logic [CFG_W-1:0]  particle_count;
  logic [SUM_W-1:0]  total;
  logic [LP_W-1:0]   pos;
  logic              set_complete;

  logic [IDX_W-1:0]  lo;
  logic [IDX_W-1:0]  hi;
  logic [IDX_W-1:0]  mid;
  logic [SUM_W-1:0]  rdata;
  logic [PROD_W-1:0] prod;
  logic [THR_W-1:0]  thr;
  logic              q_not_ready;
  logic              q_slot0;

  logic [CW-1:0]     pc_ext;
  logic [LP_W-1:0]   eff_count;
  logic [SUM_W-1:0]  base_total;
  logic [LP_W-1:0]   base_pos;
  logic [SUM_W-1:0]  total_next;
  logic [LP_W-1:0]   pos_next;
  logic [SUM_W-1:0]  w_ext;
  logic [IDX_W:0]    mid_sum;
  logic [IDX_W-1:0]  mid_next;
  logic [IDX_W+SRC_W-1:0] src_ext;

  // particle_count of zero acts as one, above the store depth as the depth
  always_comb begin
    pc_ext = CW'(particle_count);
    if (particle_count == '0) begin
      eff_count = LP_W'(1);
    end else if (pc_ext > CW'(MAX_PARTICLES)) begin
      eff_count = LP_W'(MAX_PARTICLES);
    end else begin
      eff_count = pc_ext[LP_W-1:0];
    end
  end

  assign w_ext      = SUM_W'(weight[WB_IN-1:0]);
  assign base_total = set_complete ? '0 : total;
  assign base_pos   = set_complete ? '0 : pos;
  assign total_next = base_total + w_ext;
  assign pos_next   = base_pos + LP_W'(1);

  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid_next = mid_sum[IDX_W:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      particle_count <= CFG_RESET;
      total          <= '0;
      pos            <= '0;
      set_complete   <= 1'b0;
    end else begin
      if (cfg_we) begin
        particle_count <= cfg_data;
      end
      if (cmd.load_en) begin
        if (base_pos < LP_W'(MAX_PARTICLES)) begin
          total        <= total_next;
          pos          <= pos_next;
          set_complete <= pos_next >= eff_count;
        end else begin
          total        <= base_total;
          pos          <= base_pos;
          set_complete <= base_pos >= eff_count;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_en && base_pos < LP_W'(MAX_PARTICLES)) begin
      store[base_pos[IDX_W-1:0]] <= total_next;
    end
    if (cmd.rd_en) begin
      rdata <= store[mid_next];
    end
  end

  // search bounds: first entry whose scaled sum exceeds the threshold
  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      thr         <= slot * total;
      lo          <= '0;
      hi          <= IDX_W'(pos - LP_W'(1));
      q_not_ready <= !set_complete;
      q_slot0     <= slot == '0;
    end
    if (cmd.rd_en) begin
      mid <= mid_next;
    end
    if (cmd.mul_en) begin
      prod <= rdata * pos;
    end
    if (cmd.cmp_en) begin
      if (CMP_W'(prod) > CMP_W'(thr)) begin
        hi <= mid;
      end else begin
        lo <= mid + IDX_W'(1);
      end
    end
  end

  assign src_ext = {{SRC_W{1'b0}}, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_source    <= q_not_ready ? '0 : src_ext[SRC_W-1:0];
      out_mean      <= q_not_ready ? 1'b0 : q_slot0;
      out_not_ready <= q_not_ready;
    end
  end

  assign status.set_complete = set_complete;
  assign status.search_done  = lo == hi;
  assign status.out_full     = out_valid && !out_take;

  a_load_advances: assert property (@(posedge clk) disable iff (rst)
    cmd.load_en |=> pos != '0)
    else $error("load left the position at zero");

  a_complete_bounded: assert property (@(posedge clk) disable iff (rst)
    set_complete |-> (pos != '0) && (pos <= LP_W'(MAX_PARTICLES)))
    else $error("completed set has an impossible size");

  a_mid_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.cmp_en |-> (mid >= lo) && (mid < hi))
    else $error("probe index outside search bounds");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid || out_take)
    else $error("result register overwritten while held");

endmodule

@@ rtl/systematic_resampling_index.sv @@
// ----------------------------------------------------------------------------
// systematic_resampling_index
// Particle-filter resampling index engine: weight loads and slot queries.
// ----------------------------------------------------------------------------
// A load item (tuser operation 0) appends one weight to the current set;
// once particle_count weights are in, the set is complete and the next load
// starts a new set. A query item (operation 1) binary searches the stored
// cumulative sums for the first particle whose sum times N exceeds slot
// times the set total, capped at N-1. A query holds the input until its
// result is loaded into the output register: each search step is a read
// of the single cumulative store read port, a multiply and a compare, and a
// query also waits while the previous result is still held on the output.
// A query before a set is complete skips the search, returns not_ready and
// holds the input until that result is loaded. Loads are taken while a
// result waits on the output.
// ----------------------------------------------------------------------------
module systematic_resampling_index
  import srx_pkg::*;
#(
  parameter int MAX_PARTICLES = 1024,
  parameter int WEIGHT_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration: particle_count
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_W-1:0]     cfg_data,
  // input items
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // weight[15:0], slot[25:16], zero
  input  logic                 s_tuser,   // operation
  // result items
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // source_index[9:0], zero
  output logic [M_TUSER_W-1:0] m_tuser    // use_mean_state[0], not_ready[1]
);

  srx_cmd_t          cmd;
  srx_status_t       status;
  logic [SRC_W-1:0]  out_source;
  logic              out_mean;
  logic              out_not_ready;

  assign cfg_ready = 1'b1;

  srx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_op    (s_tuser),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  srx_dp #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .WEIGHT_BITS   (WEIGHT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .weight        (s_tdata[WEIGHT_W-1:0]),
    .slot          (s_tdata[WEIGHT_W+SLOT_W-1:WEIGHT_W]),
    .cmd           (cmd),
    .status        (status),
    .out_take      (m_tready),
    .out_valid     (m_tvalid),
    .out_source    (out_source),
    .out_mean      (out_mean),
    .out_not_ready (out_not_ready)
  );

  assign m_tdata = {{(M_TDATA_W-SRC_W){1'b0}}, out_source};
  assign m_tuser = {out_not_ready, out_mean};

endmodule

@@ verif/systematic_resampling_index_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// systematic_resampling_index_tb
// Self-checking bench for the resampling index engine. A directed table and
// then random weight sets and slot queries are streamed in. The table gives
// its own expected query results; an in-bench model of the cumulative store
// predicts the others, and the results are compared in order, field by field.
// ----------------------------------------------------------------------------
module systematic_resampling_index_tb;
  import srx_pkg::*;

  localparam int ITEMS       = 1900;
  localparam int MAXP        = 1024;
  localparam int SETTLE      = 64;    // full-depth search plus output
  localparam int STALL_LIMIT = 4000;
  localparam int QUIET_TAIL  = 150;

  typedef struct packed {
    logic [SRC_W-1:0] source_index;
    logic             use_mean_state;
    logic             not_ready;
  } result_t;

  typedef enum logic [1:0] {
    ROW_LOAD,
    ROW_QUERY,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] value;   // weight, slot or particle count
    logic        typed;
    result_t     want;
  } row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;   // weight[15:0], slot[25:16], zero
  logic                 s_tuser;   // operation
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;   // source_index[9:0], zero
  logic [M_TUSER_W-1:0] m_tuser;   // use_mean_state[0], not_ready[1]

  // model of the weight set
  logic [25:0]      cum_sum [MAXP];
  logic [25:0]      set_total;
  logic [10:0]      fill_pos;
  logic             set_done;
  logic [CFG_W-1:0] part_count;

  result_t pending_q [$];
  row_t    plan_q [$];
  result_t want_now;
  int      fails;
  int      sent;
  int      idle_cycles;
  int      hold_left;
  bit      quiet;
  bit      bursty;

  systematic_resampling_index u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned eff_count();
    if (part_count == 0) return 1;
    if (part_count > MAXP) return MAXP;
    return part_count;
  endfunction

  function automatic void apply_load(logic [15:0] w);
    if (set_done) begin
      set_done  = 1'b0;
      fill_pos  = '0;
      set_total = '0;
    end
    if (fill_pos < MAXP) begin
      set_total = set_total + 26'(w);
      cum_sum[fill_pos] = set_total;
      fill_pos = fill_pos + 11'd1;
    end
    if (fill_pos >= eff_count()) set_done = 1'b1;
  endfunction

  function automatic result_t pick_source(logic [SLOT_W-1:0] slot);
    logic [63:0] n;
    logic [63:0] threshold;
    int unsigned j;
    result_t     r;
    r = '0;
    if (!set_done) begin
      r.not_ready = 1'b1;
      return r;
    end
    n = 64'(fill_pos);
    threshold = 64'(slot) * 64'(set_total);
    j = 0;
    while (j + 1 < n && 64'(cum_sum[j]) * n <= threshold) j++;
    r.source_index   = j[SRC_W-1:0];
    r.use_mean_state = (slot == 0);
    return r;
  endfunction

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [SLOT_W-1:0] rand_slot();
    int unsigned top;
    top = (fill_pos > 1023) ? 1023 : fill_pos;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return SLOT_W'($urandom_range(0, (top > 0) ? top - 1 : 0));
      4: return SLOT_W'(top);
      default: return SLOT_W'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic void add_row(row_kind_t k, int v, bit typed, int src, bit mean, bit nr);
    row_t r;
    r.kind  = k;
    r.value = 16'(v);
    r.typed = typed;
    r.want.source_index   = SRC_W'(src);
    r.want.use_mean_state = mean;
    r.want.not_ready      = nr;
    plan_q.insert(plan_q.size(), r);
  endfunction

  task automatic send_item(input logic op, input logic [15:0] w,
                           input logic [SLOT_W-1:0] slot, input bit typed,
                           input result_t want);
    int gap;
    gap = 0;
    if (bursty && !quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'b0, slot, w};
    do @(posedge clk); while (!s_tready);
    sent++;
    if (op == OP_LOAD) apply_load(w);
    else if (typed) pending_q.insert(pending_q.size(), want);
    else pending_q.insert(pending_q.size(), pick_source(slot));
  endtask

  task automatic load_weight(input logic [15:0] w);
    send_item(OP_LOAD, w, SLOT_W'($urandom_range(0, 1023)), 1'b0, '0);
  endtask

  task automatic query_slot(input logic [SLOT_W-1:0] slot);
    send_item(OP_QUERY, 16'($urandom), slot, 1'b0, '0);
  endtask

  // load until the model reports a complete set
  task automatic fill_set();
    do load_weight(rand_weight()); while (!set_done);
  endtask

  task automatic ask(input int n);
    repeat (n) query_slot(rand_slot());
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_count(input logic [CFG_W-1:0] v);
    drain_and_settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    part_count = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side: random stall bursts, none in calm phases or the tail
  always @(negedge clk) begin
    if (quiet || !bursty) begin
      m_tready <= 1'b1;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      hold_left = $urandom_range(0, 6);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_q.size() == 0) begin
        $error("result item with none pending: source_index %0d", m_tdata[SRC_W-1:0]);
        fails++;
      end else begin
        want_now = pending_q.pop_front();
        if (m_tdata[SRC_W-1:0] !== want_now.source_index) begin
          $error("source_index: expected %0d, got %0d",
                 want_now.source_index, m_tdata[SRC_W-1:0]);
          fails++;
        end
        if (m_tuser[0] !== want_now.use_mean_state) begin
          $error("use_mean_state: expected %0b, got %0b", want_now.use_mean_state, m_tuser[0]);
          fails++;
        end
        if (m_tuser[1] !== want_now.not_ready) begin
          $error("not_ready: expected %0b, got %0b", want_now.not_ready, m_tuser[1]);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("systematic_resampling_index: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int style;
    int k;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = OP_LOAD;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    fails     = 0;
    sent      = 0;
    hold_left = 0;
    idle_cycles = 0;
    quiet     = 1'b0;
    bursty    = 1'b1;
    set_total = '0;
    fill_pos  = '0;
    set_done  = 1'b0;
    part_count = CFG_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // nothing loaded yet
    add_row(ROW_QUERY, 0, 1, 0, 0, 1);
    add_row(ROW_QUERY, 1023, 1, 0, 0, 1);
    // three heavy/empty/heavy weights, partial set first
    add_row(ROW_CFG, 3, 0, 0, 0, 0);
    add_row(ROW_LOAD, 16'hFFFF, 0, 0, 0, 0);
    add_row(ROW_LOAD, 0, 0, 0, 0, 0);
    add_row(ROW_QUERY, 1, 1, 0, 0, 1);
    add_row(ROW_LOAD, 16'hFFFF, 0, 0, 0, 0);
    add_row(ROW_QUERY, 0, 1, 0, 1, 0);
    add_row(ROW_QUERY, 1, 0, 0, 0, 0);
    add_row(ROW_QUERY, 2, 0, 0, 0, 0);
    add_row(ROW_QUERY, 1023, 1, 2, 0, 0);
    // count 0 acts as a single particle
    add_row(ROW_CFG, 0, 0, 0, 0, 0);
    add_row(ROW_LOAD, 16'h1234, 0, 0, 0, 0);
    add_row(ROW_QUERY, 5, 1, 0, 0, 0);
    // shrink the count mid-set, all weights zero
    add_row(ROW_CFG, 4, 0, 0, 0, 0);
    add_row(ROW_LOAD, 0, 0, 0, 0, 0);
    add_row(ROW_LOAD, 0, 0, 0, 0, 0);
    add_row(ROW_CFG, 2, 0, 0, 0, 0);
    add_row(ROW_LOAD, 0, 0, 0, 0, 0);
    add_row(ROW_QUERY, 1, 1, 2, 0, 0);
    add_row(ROW_QUERY, 0, 1, 2, 1, 0);
    // oversized count clamps to the full store
    add_row(ROW_CFG, 2047, 0, 0, 0, 0);

    foreach (plan_q[i]) begin
      case (plan_q[i].kind)
        ROW_LOAD:  load_weight(plan_q[i].value);
        ROW_QUERY: send_item(OP_QUERY, 16'($urandom), plan_q[i].value[SLOT_W-1:0],
                             plan_q[i].typed, plan_q[i].want);
        default:   write_count(plan_q[i].value[CFG_W-1:0]);
      endcase
    end

    // one full-depth set
    fill_set();
    ask(40);

    while (sent < ITEMS) begin
      if (sent >= ITEMS - QUIET_TAIL) quiet = 1'b1;
      bursty = !quiet && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: write_count('0);
        1: write_count(CFG_W'(1));
        9: write_count(CFG_W'($urandom_range(25, 64)));
        default: write_count(CFG_W'($urandom_range(2, 24)));
      endcase
      style = $urandom_range(0, 9);
      if (style <= 6) begin
        if ($urandom_range(0, 3) == 0) query_slot(rand_slot());
        fill_set();
        ask($urandom_range(2, 12));
      end else if (style == 7) begin
        // up to a full set of loads, queries, then a new count and a full set
        k = $urandom_range(1, eff_count());
        repeat (k) load_weight(rand_weight());
        ask(2);
        write_count(CFG_W'($urandom_range(1, 24)));
        fill_set();
        ask($urandom_range(2, 8));
      end else if (style == 8) begin
        // restart a completed set with one load
        fill_set();
        ask(3);
        load_weight(rand_weight());
        ask(2);
        fill_set();
        ask($urandom_range(2, 8));
      end else begin
        repeat (12) begin
          if ($urandom_range(0, 1) == 0) load_weight(16'($urandom));
          else query_slot(SLOT_W'($urandom_range(0, 1023)));
        end
      end
    end

    drain_and_settle();
    if (fails == 0) begin
      $display("systematic_resampling_index: match");
    end else begin
      $display("systematic_resampling_index: mismatch");
    end
    $finish;
  end

endmodule
